// ===== src/lnps_pkg.sv =====
package lnps_pkg;

    // accumulator width: largest sum is a 32 x 47 bit product plus three small ones
    localparam int ACC_W = 82;
    // multiplier operand width: signed 32-bit gains and a 32-bit magnitude
    localparam int MB_W  = 33;

    localparam int NREG = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIN_GAIN_Y  = 3'd0,
        REG_LIN_GAIN_U  = 3'd1,
        REG_NON_GAIN_Y  = 3'd2,
        REG_NON_GAIN_SQ = 3'd3,
        REG_NON_GAIN_U  = 3'd4,
        REG_NON_GAIN_SIN = 3'd5
    } reg_idx_t;

    localparam logic signed [31:0] RST_LIN_GAIN_Y   = 32'sd49152;
    localparam logic signed [31:0] RST_LIN_GAIN_U   = 32'sd11796;
    localparam logic signed [31:0] RST_NON_GAIN_Y   = 32'sd49152;
    localparam logic signed [31:0] RST_NON_GAIN_SQ  = 32'sd11796;
    localparam logic signed [31:0] RST_NON_GAIN_U   = 32'sd4588;
    localparam logic signed [31:0] RST_NON_GAIN_SIN = 32'sd7864;

    // angle constants in Q5.30
    localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
    localparam logic [45:0] RED_DIV_INIT = 46'd6746518852 << 13;
    localparam int RED_STEPS = 14;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } top_state_t;

    // product sequence of one step
    typedef enum logic [2:0] {
        OP_MAG_SQ = 3'd0,
        OP_LIN_Y  = 3'd1,
        OP_LIN_U  = 3'd2,
        OP_NON_Y  = 3'd3,
        OP_NON_U  = 3'd4,
        OP_SQG    = 3'd5,
        OP_SIN    = 3'd6,
        OP_END    = 3'd7
    } op_t;

    // sine unit states
    typedef enum logic [1:0] {
        SN_IDLE,
        SN_RED,
        SN_FIX,
        SN_ROT
    } sine_state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } rnd_t;

    // round half up to Q16.16 and saturate to 32 bits
    function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-17:0] v;
        rnd_t r;
        t = acc + ACC_W'(32768);
        v = t[ACC_W-1:16];
        if (v[ACC_W-17:31] == '0 || v[ACC_W-17:31] == '1)
        begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        else if (v[ACC_W-17])
        begin
            r.val  = 32'sh8000_0000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = 32'sh7fff_ffff;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    // arctan(2^-i) in unsigned Q1.30
    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] r;
        case (i)
            5'd0:  r = 31'd843314857;
            5'd1:  r = 31'd497837829;
            5'd2:  r = 31'd263043837;
            5'd3:  r = 31'd133525159;
            5'd4:  r = 31'd67021687;
            5'd5:  r = 31'd33543516;
            5'd6:  r = 31'd16775851;
            5'd7:  r = 31'd8388437;
            5'd8:  r = 31'd4194283;
            5'd9:  r = 31'd2097149;
            5'd10: r = 31'd1048576;
            5'd11: r = 31'd524288;
            5'd12: r = 31'd262144;
            5'd13: r = 31'd131072;
            5'd14: r = 31'd65536;
            5'd15: r = 31'd32768;
            5'd16: r = 31'd16384;
            5'd17: r = 31'd8192;
            5'd18: r = 31'd4096;
            5'd19: r = 31'd2048;
            5'd20: r = 31'd1024;
            5'd21: r = 31'd512;
            5'd22: r = 31'd256;
            5'd23: r = 31'd128;
            5'd24: r = 31'd64;
            5'd25: r = 31'd32;
            5'd26: r = 31'd16;
            5'd27: r = 31'd8;
            5'd28: r = 31'd4;
            5'd29: r = 31'd2;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/linear_nonlinear_plant_step.sv =====
// channel | dir | handshake               | payload
// input   | in  | in_valid / in_stall     | drive
// output  | out | out_valid / out_stall   | linear_out, nonlinear_out, saturated
// config  | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
// one request at a time; each product runs on a bit-serial multiplier with a 33-bit multiplier operand;
// seven products per request,
// four products on the first step after reset
// the sine unit (restoring reduction, fold, then CORDIC rotations) runs alongside
// reset restores the gains and clears all histories; output stall holds the result
module linear_nonlinear_plant_step #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            drive,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            linear_out,
    output logic signed [31:0]            nonlinear_out,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lnps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import lnps_pkg::*;

    top_state_t state_reg, state_next;
    op_t        op_reg, op_next;

    logic signed [31:0] gain_reg [NREG];
    logic signed [31:0] lin_prev_reg, non_prev_reg, non_prev2_reg, drive_prev_reg;
    logic signed [31:0] u_reg;
    logic               started_reg;
    logic [46:0]        sq_reg;
    logic signed [31:0] lin_res_reg;
    logic               lin_clip_reg;
    logic               out_valid_reg;
    logic signed [31:0] lin_out_reg, non_out_reg;
    logic               sat_reg;

    mac_ctrl_t          mac_ctrl;
    logic signed [ACC_W-1:0] mac_a, mac_acc;
    logic signed [MB_W-1:0]  mac_b;
    logic               mac_done;
    logic               sin_done;
    logic signed [17:0] sin_val;
    logic               in_acc, out_acc, finish;
    logic [31:0]        np2_mag;
    logic [ACC_W-1:0]   sq_sum;
    rnd_t               rnd;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign finish   = (state_reg == ST_DONE) && !(out_valid_reg && out_stall);
    assign np2_mag  = non_prev2_reg[31] ? 32'(-non_prev2_reg) : non_prev2_reg;
    assign sq_sum   = mac_acc + ACC_W'(32768);
    assign rnd      = round_sat(mac_acc);

    lnps_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .done (mac_done),
        .acc  (mac_acc)
    );

    lnps_sine #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_sine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_acc),
        .angle (drive_prev_reg),
        .done  (sin_done),
        .result(sin_val)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_ISSUE;
                    op_next    = started_reg ? OP_MAG_SQ : OP_LIN_Y;
                end
            end
            ST_ISSUE:
            begin
                if (op_reg != OP_SIN || sin_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    if (op_reg == OP_SIN || (op_reg == OP_NON_U && !started_reg))
                    begin
                        state_next = ST_DONE;
                        op_next    = OP_END;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        op_next    = op_t'(op_reg + 3'd1);
                    end
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: multiplier requests and operand select
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        if (state_reg == ST_ISSUE && (op_reg != OP_SIN || sin_done))
        begin
            mac_ctrl.start = 1'b1;
        end
        case (op_reg)
            OP_MAG_SQ:
            begin
                mac_ctrl.clear = 1'b1;
                mac_a = ACC_W'(np2_mag);
                mac_b = {1'b0, np2_mag};
            end
            OP_LIN_Y:
            begin
                mac_ctrl.clear = 1'b1;
                mac_a = ACC_W'(lin_prev_reg);
                mac_b = MB_W'(gain_reg[REG_LIN_GAIN_Y]);
            end
            OP_LIN_U:
            begin
                mac_a = ACC_W'(u_reg);
                mac_b = MB_W'(gain_reg[REG_LIN_GAIN_U]);
            end
            OP_NON_Y:
            begin
                mac_ctrl.clear = 1'b1;
                mac_a = ACC_W'(non_prev_reg);
                mac_b = MB_W'(gain_reg[REG_NON_GAIN_Y]);
            end
            OP_NON_U:
            begin
                mac_a = ACC_W'(u_reg);
                mac_b = MB_W'(gain_reg[REG_NON_GAIN_U]);
            end
            OP_SQG:
            begin
                mac_ctrl.sub = 1'b1;
                mac_a = ACC_W'(sq_reg);
                mac_b = MB_W'(gain_reg[REG_NON_GAIN_SQ]);
            end
            OP_SIN:
            begin
                mac_a = ACC_W'(sin_val);
                mac_b = MB_W'(gain_reg[REG_NON_GAIN_SIN]);
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
    end

    // control state, gains and histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_END;
            out_valid_reg  <= 1'b0;
            started_reg    <= 1'b0;
            lin_prev_reg   <= '0;
            non_prev_reg   <= '0;
            non_prev2_reg  <= '0;
            drive_prev_reg <= '0;
            gain_reg[REG_LIN_GAIN_Y]   <= RST_LIN_GAIN_Y;
            gain_reg[REG_LIN_GAIN_U]   <= RST_LIN_GAIN_U;
            gain_reg[REG_NON_GAIN_Y]   <= RST_NON_GAIN_Y;
            gain_reg[REG_NON_GAIN_SQ]  <= RST_NON_GAIN_SQ;
            gain_reg[REG_NON_GAIN_U]   <= RST_NON_GAIN_U;
            gain_reg[REG_NON_GAIN_SIN] <= RST_NON_GAIN_SIN;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NREG))
            begin
                gain_reg[cfg_index] <= cfg_data;
            end
            if (finish)
            begin
                out_valid_reg  <= 1'b1;
                started_reg    <= 1'b1;
                lin_prev_reg   <= lin_res_reg;
                non_prev_reg   <= rnd.val;
                non_prev2_reg  <= non_prev_reg;
                drive_prev_reg <= u_reg;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload captures
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            u_reg <= drive;
        end
        if (state_reg == ST_WAIT && mac_done && op_reg == OP_MAG_SQ)
        begin
            sq_reg <= sq_sum[62:16];
        end
        if (state_reg == ST_WAIT && mac_done && op_reg == OP_LIN_U)
        begin
            lin_res_reg  <= rnd.val;
            lin_clip_reg <= rnd.clip;
        end
        if (finish)
        begin
            lin_out_reg <= lin_res_reg;
            non_out_reg <= rnd.val;
            sat_reg     <= lin_clip_reg | rnd.clip;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign linear_out    = lin_out_reg;
    assign nonlinear_out = non_out_reg;
    assign saturated     = sat_reg;

    a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_ISSUE && (op_reg == OP_MAG_SQ || op_reg == OP_LIN_Y))
        else $error("request did not start the product sequence");
    a_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE && !started_reg |-> op_reg != OP_SQG && op_reg != OP_SIN
        && op_reg != OP_MAG_SQ)
        else $error("history terms used on first step");
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && started_reg && state_reg == ST_IDLE)
        else $error("finished step not presented");
    a_sin_ready: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctrl.start && op_reg == OP_SIN |-> sin_done)
        else $error("sine used before ready");

endmodule

// ===== src/lnps_mac.sv =====
module lnps_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lnps_pkg::mac_ctrl_t               ctrl,
    input  logic signed [lnps_pkg::ACC_W-1:0] a,
    input  logic signed [lnps_pkg::MB_W-1:0]  b,
    output logic                              done,
    output logic signed [lnps_pkg::ACC_W-1:0] acc
);
    import lnps_pkg::*;

    localparam int CNT_W = $clog2(MB_W);

    logic signed [ACC_W-1:0] a_sh_reg, a_sh_next;
    logic signed [MB_W-1:0]  b_sh_reg, b_sh_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    sub_reg, sub_next;
    logic signed [ACC_W-1:0] term;
    logic                    last;

    // one multiplier bit per cycle, lsb first, sign bit weighs negative
    always_comb
    begin
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sub_next  = sub_reg;
        last      = (cnt_reg == CNT_W'(MB_W - 1));
        term      = b_sh_reg[0] ? a_sh_reg : '0;
        if (ctrl.start)
        begin
            a_sh_next = a;
            b_sh_next = b;
            cnt_next  = '0;
            busy_next = 1'b1;
            sub_next  = ctrl.sub;
            if (ctrl.clear)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            acc_next  = (last ^ sub_reg) ? acc_reg - term : acc_reg + term;
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >>> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
        sub_reg  <= sub_next;
    end

    assign done = !busy_reg;
    assign acc  = acc_reg;

    // start pulse runs the unit
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> busy_reg && cnt_reg == '0)
        else $error("mac did not start");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_W'(MB_W - 1))
        else $error("mac bit count out of range");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !ctrl.start |=> !busy_reg)
        else $error("mac busy without start");

endmodule

// ===== src/lnps_sine.sv =====
module lnps_sine #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [17:0] result
);
    import lnps_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int KW = $clog2(RED_STEPS);

    sine_state_t state_reg, state_next;
    logic [45:0]       rem_reg, rem_next;
    logic [45:0]       div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [IW-1:0]     i_reg, i_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [34:0] z_reg, z_next;

    logic [31:0]        mag;
    logic signed [34:0] r_s, z0, z1, z2, at;
    logic signed [33:0] xs, ys;
    logic signed [33:0] y_rnd;
    logic signed [19:0] y_q16;

    assign mag = angle[31] ? 32'(-angle) : angle;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SN_IDLE:
            begin
                if (start)
                begin
                    state_next = SN_RED;
                end
            end
            SN_RED:
            begin
                if (k_reg == KW'(RED_STEPS - 1))
                begin
                    state_next = SN_FIX;
                end
            end
            SN_FIX:
            begin
                state_next = SN_ROT;
            end
            SN_ROT:
            begin
                if (i_reg == IW'(CORDIC_STEPS - 1))
                begin
                    state_next = SN_IDLE;
                end
            end
            default:
            begin
                state_next = SN_IDLE;
            end
        endcase
    end

    // datapath: restoring reduction, then fold, then rotations
    always_comb
    begin
        rem_next = rem_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        k_next   = k_reg;
        i_next   = i_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        r_s = 35'(rem_reg[33:0]);
        z0  = (neg_reg && rem_reg != '0) ? Q30_TWO_PI - r_s : r_s;
        z1  = (z0 > Q30_PI) ? z0 - Q30_TWO_PI : z0;
        if (z1 > Q30_HALF_PI)
        begin
            z2 = Q30_PI - z1;
        end
        else if (z1 < -Q30_HALF_PI)
        begin
            z2 = -Q30_PI - z1;
        end
        else
        begin
            z2 = z1;
        end
        at = 35'(atan_q30(5'(i_reg)));
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        case (state_reg)
            SN_IDLE:
            begin
                if (start)
                begin
                    rem_next = {mag, 14'd0};
                    div_next = RED_DIV_INIT;
                    neg_next = angle[31];
                    k_next   = '0;
                end
            end
            SN_RED:
            begin
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                end
                div_next = div_reg >> 1;
                k_next   = k_reg + 1'b1;
            end
            SN_FIX:
            begin
                z_next = z2;
                x_next = Q30_GAIN;
                y_next = '0;
                i_next = '0;
            end
            SN_ROT:
            begin
                if (!z_reg[34])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                i_next = i_reg + 1'b1;
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SN_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    // round Q30 to Q16 and clamp to [-1, 1]
    always_comb
    begin
        y_rnd = y_reg + 34'sd8192;
        y_q16 = y_rnd[33:14];
        if (y_q16 > 20'sd65536)
        begin
            result = 18'sd65536;
        end
        else if (y_q16 < -20'sd65536)
        begin
            result = -18'sd65536;
        end
        else
        begin
            result = y_q16[17:0];
        end
    end

    assign done = (state_reg == SN_IDLE);

    a_red_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SN_RED && k_reg == KW'(RED_STEPS - 1) |=> state_reg == SN_FIX)
        else $error("reduction length wrong");
    a_rot_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SN_FIX |=> state_reg == SN_ROT && i_reg == '0)
        else $error("rotation did not start");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SN_FIX |-> rem_reg < 46'd6746518852)
        else $error("reduction left remainder too large");

endmodule
